// File: sv/stop_and_wait_arq_link_top_macros.svh
// ---------------------------------------------------------------------------
// stop_and_wait_arq_link_top assertion macros
// Shared concurrent assertion forms for the link checker.
// ---------------------------------------------------------------------------
`ifndef STOP_AND_WAIT_ARQ_LINK_TOP_MACROS_SVH
`define STOP_AND_WAIT_ARQ_LINK_TOP_MACROS_SVH

// same-cycle implication
`define SAW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("link assertion failed");

// next-cycle implication
`define SAW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("link assertion failed");

`endif

// File: sv/sawarq_pkg.sv
// ---------------------------------------------------------------------------
// sawarq_pkg
// Types, codes and helpers for the stop-and-wait ARQ link controller.
// ---------------------------------------------------------------------------
package sawarq_pkg;

  localparam int SEQ_MODULUS = 256;
  localparam logic [7:0] BROADCAST_NODE = 8'hFF;

  // pending event bits
  localparam int EV_SEND     = 0;
  localparam int EV_DATA     = 1;
  localparam int EV_ACKRX    = 2;
  localparam int EV_TIMEOUT  = 3;
  localparam int EV_DATADONE = 4;
  localparam int EV_ACKDONE  = 5;
  localparam int EV_NUM      = 6;

  typedef enum logic [2:0] {
    FN_POLL     = 3'd0,
    FN_SEND     = 3'd1,
    FN_DATA     = 3'd2,
    FN_ACKRX    = 3'd3,
    FN_TIMEOUT  = 3'd4,
    FN_DATADONE = 3'd5,
    FN_ACKDONE  = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_TX      = 2'd1,
    ST_ACKWAIT = 2'd2
  } state_t;

  typedef enum logic [1:0] {
    TX_NONE = 2'd0,
    TX_DATA = 2'd1,
    TX_ACK  = 2'd2,
    TX_RETX = 2'd3
  } tx_kind_t;

  typedef enum logic [1:0] {
    CF_NONE = 2'd0,
    CF_OK   = 2'd1,
    CF_FAIL = 2'd2
  } confirm_t;

  // action chosen by one pass
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_DROP,
    ACT_RX_BC,
    ACT_RX_UC,
    ACT_SEND,
    ACT_TO_WAIT,
    ACT_TO_IDLE,
    ACT_BC_DONE,
    ACT_ARM,
    ACT_ACK_OK,
    ACT_FAIL,
    ACT_RETX
  } act_t;

  function automatic logic [7:0] seq_inc(logic [7:0] s);
    logic [8:0] sum;
    sum = {1'b0, s} + 9'd1;
    if (sum >= 9'(SEQ_MODULUS)) begin
      sum = sum - 9'(SEQ_MODULUS);
    end
    return sum[7:0];
  endfunction

endpackage

// File: sv/stop_and_wait_arq_link_top.sv
// ---------------------------------------------------------------------------
// stop_and_wait_arq_link_top
// Control side of a stop-and-wait ARQ link: event in, one decision out.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one event item per transfer:
//   a poll, send request, data or ack frame received, timeout, data sent or
//   ack sent, with the frame fields that go with it.
//   The block latches the event as pending and runs one prioritized pass,
//   giving exactly one result item per input item on out_valid/out_stall:
//   frame to transmit, send confirm, delivery upward and the new link state.
//   out_valid is registered and is high in the cycle after input accept.
//   Throughput: 1 item per cycle unless stalled; the pass is a single level of
//   decision logic between the state registers and the result register.
//   When the receiver stalls, the result register holds and in_stall rises
//   for as long as a full result register is not taken.
//   cfg_wr_en/cfg_wr_data write max_retransmissions; write only while idle.
//   Reset (rst_n low, synchronous): link idle, counters and pending events
//   clear, max_retransmissions = 3, no result pending.
// ---------------------------------------------------------------------------
module stop_and_wait_arq_link_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sawarq_pkg::func_t     in_func,
  input  logic [7:0]            in_rx_seq,
  input  logic [7:0]            in_rx_src,
  input  logic                  in_rx_broadcast,
  input  logic                  in_rx_last,
  input  logic [7:0]            in_dest_id,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sawarq_pkg::tx_kind_t  out_tx_kind,
  output logic [7:0]            out_tx_seq,
  output logic [7:0]            out_tx_dest,
  output sawarq_pkg::confirm_t  out_confirm,
  output logic                  out_deliver,
  output logic [7:0]            out_deliver_src,
  output logic                  out_deliver_last,
  output sawarq_pkg::state_t    out_link_state,
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data
);
  import sawarq_pkg::*;

  logic              acc;
  logic [7:0]        max_retx_r;

  state_t            state_r, state_nxt;
  logic [7:0]        next_seq_r, next_seq_nxt;
  logic [7:0]        sent_seq_r, sent_seq_nxt;
  logic [7:0]        retry_r, retry_nxt;
  logic [7:0]        dest_node_r, dest_node_nxt;
  logic              timer_r, timer_nxt;
  logic [EV_NUM-1:0] pend_r, pend_nxt;
  logic [7:0]        held_rx_seq_r, held_rx_seq_nxt;
  logic [7:0]        held_rx_src_r, held_rx_src_nxt;
  logic              held_bc_r, held_bc_nxt;
  logic              held_last_r, held_last_nxt;
  logic [7:0]        held_ack_seq_r, held_ack_seq_nxt;

  logic [EV_NUM-1:0] pend_post;
  logic              timer_post;
  logic [EV_NUM-1:0] clr;
  act_t              act;

  logic              out_valid_r;
  tx_kind_t          tx_kind_r, tx_kind_nxt;
  logic [7:0]        tx_seq_r, tx_seq_nxt;
  logic [7:0]        tx_dest_r, tx_dest_nxt;
  confirm_t          confirm_r, confirm_nxt;
  logic              deliver_r, deliver_nxt;
  logic [7:0]        dlv_src_r, dlv_src_nxt;
  logic              dlv_last_r, dlv_last_nxt;
  state_t            link_state_r;

  assign in_stall = out_valid_r & out_stall;
  assign acc      = in_valid & ~in_stall;

  // post the incoming event
  always_comb begin
    pend_post        = pend_r;
    timer_post       = timer_r;
    dest_node_nxt    = dest_node_r;
    held_rx_seq_nxt  = held_rx_seq_r;
    held_rx_src_nxt  = held_rx_src_r;
    held_bc_nxt      = held_bc_r;
    held_last_nxt    = held_last_r;
    held_ack_seq_nxt = held_ack_seq_r;
    unique case (in_func)
      FN_SEND: begin
        dest_node_nxt     = in_dest_id;
        pend_post[EV_SEND] = 1'b1;
      end
      FN_DATA: begin
        held_rx_seq_nxt    = in_rx_seq;
        held_rx_src_nxt    = in_rx_src;
        held_bc_nxt        = in_rx_broadcast;
        held_last_nxt      = in_rx_last;
        pend_post[EV_DATA] = 1'b1;
      end
      FN_ACKRX: begin
        held_ack_seq_nxt    = in_rx_seq;
        pend_post[EV_ACKRX] = 1'b1;
      end
      FN_TIMEOUT: begin
        timer_post            = 1'b0;
        pend_post[EV_TIMEOUT] = 1'b1;
      end
      FN_DATADONE: pend_post[EV_DATADONE] = 1'b1;
      FN_ACKDONE:  pend_post[EV_ACKDONE]  = 1'b1;
      default: ;
    endcase
  end

  // one prioritized pass over the pending events
  always_comb begin
    act = ACT_NONE;
    clr = '0;
    unique case (state_r)
      ST_IDLE: begin
        priority if (pend_post[EV_DATA]) begin
          act = held_bc_nxt ? ACT_RX_BC : ACT_RX_UC;
          clr[EV_DATA] = 1'b1;
        end else if (pend_post[EV_SEND]) begin
          act = ACT_SEND;
          clr[EV_SEND] = 1'b1;
        end else if (pend_post[EV_DATADONE]) begin
          act = ACT_DROP;
          clr[EV_DATADONE] = 1'b1;
        end else if (pend_post[EV_ACKDONE]) begin
          act = ACT_DROP;
          clr[EV_ACKDONE] = 1'b1;
        end else if (pend_post[EV_TIMEOUT]) begin
          act = ACT_DROP;
          clr[EV_TIMEOUT] = 1'b1;
        end else begin
          act = ACT_NONE;
        end
      end
      ST_TX: begin
        priority if (pend_post[EV_ACKDONE]) begin
          act = (timer_post || pend_post[EV_TIMEOUT]) ? ACT_TO_WAIT : ACT_TO_IDLE;
          clr[EV_ACKDONE] = 1'b1;
        end else if (pend_post[EV_DATADONE]) begin
          act = (dest_node_nxt == BROADCAST_NODE) ? ACT_BC_DONE : ACT_ARM;
          clr[EV_DATADONE] = 1'b1;
        end else begin
          act = ACT_NONE;
        end
      end
      ST_ACKWAIT: begin
        priority if (pend_post[EV_ACKRX]) begin
          act = (held_ack_seq_nxt == sent_seq_r) ? ACT_ACK_OK : ACT_DROP;
          clr[EV_ACKRX] = 1'b1;
        end else if (pend_post[EV_TIMEOUT]) begin
          act = (retry_r >= max_retx_r) ? ACT_FAIL : ACT_RETX;
          clr[EV_TIMEOUT] = 1'b1;
        end else if (pend_post[EV_DATA]) begin
          act = held_bc_nxt ? ACT_RX_BC : ACT_RX_UC;
          clr[EV_DATA] = 1'b1;
        end else if (pend_post[EV_DATADONE]) begin
          act = ACT_DROP;
          clr[EV_DATADONE] = 1'b1;
        end else if (pend_post[EV_ACKDONE]) begin
          act = ACT_DROP;
          clr[EV_ACKDONE] = 1'b1;
        end else begin
          act = ACT_NONE;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt    = state_r;
    next_seq_nxt = next_seq_r;
    sent_seq_nxt = sent_seq_r;
    retry_nxt    = retry_r;
    timer_nxt    = timer_post;
    pend_nxt     = pend_post & ~clr;
    unique case (act)
      ACT_RX_BC: state_nxt = ST_IDLE;
      ACT_RX_UC: begin
        next_seq_nxt = seq_inc(held_rx_seq_nxt);
        state_nxt    = ST_TX;
      end
      ACT_SEND: begin
        sent_seq_nxt = next_seq_r;
        if (dest_node_nxt != BROADCAST_NODE) begin
          next_seq_nxt = seq_inc(next_seq_r);
        end
        retry_nxt = '0;
        state_nxt = ST_TX;
      end
      ACT_TO_WAIT: state_nxt = ST_ACKWAIT;
      ACT_TO_IDLE: state_nxt = ST_IDLE;
      ACT_BC_DONE: state_nxt = ST_IDLE;
      ACT_ARM: begin
        state_nxt = ST_ACKWAIT;
        timer_nxt = 1'b1;
      end
      ACT_ACK_OK: begin
        state_nxt = ST_IDLE;
        timer_nxt = 1'b0;
      end
      ACT_FAIL: state_nxt = ST_IDLE;
      ACT_RETX: begin
        retry_nxt = retry_r + 8'd1;
        state_nxt = ST_TX;
      end
      default: ;
    endcase
  end

  // result fields
  always_comb begin
    tx_kind_nxt  = TX_NONE;
    tx_seq_nxt   = '0;
    tx_dest_nxt  = '0;
    confirm_nxt  = CF_NONE;
    deliver_nxt  = 1'b0;
    dlv_src_nxt  = '0;
    dlv_last_nxt = 1'b0;
    unique case (act)
      ACT_RX_BC: begin
        deliver_nxt  = 1'b1;
        dlv_src_nxt  = held_rx_src_nxt;
        dlv_last_nxt = 1'b1;
      end
      ACT_RX_UC: begin
        deliver_nxt  = 1'b1;
        dlv_src_nxt  = held_rx_src_nxt;
        dlv_last_nxt = held_last_nxt;
        tx_kind_nxt  = TX_ACK;
        tx_seq_nxt   = held_rx_seq_nxt;
        tx_dest_nxt  = held_rx_src_nxt;
      end
      ACT_SEND: begin
        tx_kind_nxt = TX_DATA;
        tx_seq_nxt  = next_seq_r;
        tx_dest_nxt = dest_node_nxt;
      end
      ACT_RETX: begin
        tx_kind_nxt = TX_RETX;
        tx_seq_nxt  = sent_seq_r;
        tx_dest_nxt = dest_node_nxt;
      end
      ACT_BC_DONE, ACT_ACK_OK: confirm_nxt = CF_OK;
      ACT_FAIL:                confirm_nxt = CF_FAIL;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_retx_r     <= 8'd3;
      state_r        <= ST_IDLE;
      next_seq_r     <= '0;
      sent_seq_r     <= '0;
      retry_r        <= '0;
      dest_node_r    <= '0;
      timer_r        <= 1'b0;
      pend_r         <= '0;
      held_rx_seq_r  <= '0;
      held_rx_src_r  <= '0;
      held_bc_r      <= 1'b0;
      held_last_r    <= 1'b0;
      held_ack_seq_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_retx_r <= cfg_wr_data;
      end
      if (acc) begin
        state_r        <= state_nxt;
        next_seq_r     <= next_seq_nxt;
        sent_seq_r     <= sent_seq_nxt;
        retry_r        <= retry_nxt;
        dest_node_r    <= dest_node_nxt;
        timer_r        <= timer_nxt;
        pend_r         <= pend_nxt;
        held_rx_seq_r  <= held_rx_seq_nxt;
        held_rx_src_r  <= held_rx_src_nxt;
        held_bc_r      <= held_bc_nxt;
        held_last_r    <= held_last_nxt;
        held_ack_seq_r <= held_ack_seq_nxt;
        out_valid_r    <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (acc) begin
      tx_kind_r    <= tx_kind_nxt;
      tx_seq_r     <= tx_seq_nxt;
      tx_dest_r    <= tx_dest_nxt;
      confirm_r    <= confirm_nxt;
      deliver_r    <= deliver_nxt;
      dlv_src_r    <= dlv_src_nxt;
      dlv_last_r   <= dlv_last_nxt;
      link_state_r <= state_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tx_kind      = tx_kind_r;
  assign out_tx_seq       = tx_seq_r;
  assign out_tx_dest      = tx_dest_r;
  assign out_confirm      = confirm_r;
  assign out_deliver      = deliver_r;
  assign out_deliver_src  = dlv_src_r;
  assign out_deliver_last = dlv_last_r;
  assign out_link_state   = link_state_r;

endmodule

// File: sv/sawarq_chk.sv
// ---------------------------------------------------------------------------
// sawarq_chk
// Port-level checks for the stop-and-wait ARQ link, bound to the top level.
// ---------------------------------------------------------------------------
`include "stop_and_wait_arq_link_top_macros.svh"

module sawarq_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input sawarq_pkg::tx_kind_t  out_tx_kind,
  input logic [7:0]            out_tx_seq,
  input logic [7:0]            out_tx_dest,
  input sawarq_pkg::confirm_t  out_confirm,
  input logic                  out_deliver,
  input logic [7:0]            out_deliver_src,
  input logic                  out_deliver_last,
  input sawarq_pkg::state_t    out_link_state
);
  import sawarq_pkg::*;

  // held result stays put
  `SAW_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_tx_kind) && $stable(out_tx_seq) && $stable(out_link_state))

  // every accepted item gives a result next cycle
  `SAW_ASSERT_NXT(a_one_result, in_valid && !in_stall, out_valid)

  `SAW_ASSERT_IMP(a_tx_unused, out_valid && out_tx_kind == TX_NONE, out_tx_seq == 8'd0 && out_tx_dest == 8'd0)

  `SAW_ASSERT_IMP(a_dlv_unused, out_valid && !out_deliver, out_deliver_src == 8'd0 && !out_deliver_last)

  // a confirm always ends in idle
  `SAW_ASSERT_IMP(a_confirm_idle, out_valid && out_confirm != CF_NONE, out_link_state == ST_IDLE)

endmodule

bind stop_and_wait_arq_link_top sawarq_chk u_sawarq_chk (.*);
